@@ rtl/core/pfts_pkg.sv @@
// Shared types and constants of the priority frame transmit scheduler.
// Used by the queue cell and the top level; no dependencies.
`default_nettype none

package pfts_pkg;

    localparam int unsigned PRI_W   = 3;
    localparam int unsigned TAG_W   = 16;
    localparam int unsigned BYTES_W = 11;
    localparam int unsigned SEQ_W   = 32;
    localparam int unsigned BITS_W  = 15;
    localparam int unsigned REG_W   = 7;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned CIDX_W  = 2;

    localparam logic [BYTES_W-1:0] MIN_PAYLOAD = 11'd46;
    localparam logic [BYTES_W-1:0] MAX_PAYLOAD = 11'd1500;
    localparam logic [BYTES_W-1:0] BYTES_MAX   = 11'd2047;
    localparam logic [REG_W-1:0]   GAP_BITS    = 7'd96;
    localparam logic [REG_W-1:0]   HDR_RESET   = 7'd18;
    localparam logic [REG_W-1:0]   BPT_RESET   = 7'd1;

    localparam logic REQ_ENQUEUE = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    localparam logic [1:0] EV_LAUNCH    = 2'd0;
    localparam logic [1:0] EV_DROP_SIZE = 2'd1;
    localparam logic [1:0] EV_DROP_FULL = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_SWITCH    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_HEADER    = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_BPT       = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_SEQ_START = 2'd3;

    typedef enum logic [1:0] {
        PORT_IDLE = 2'd0,
        PORT_TX   = 2'd1,
        PORT_GAP  = 2'd2
    } t_port;

    typedef struct packed {
        logic [PRI_W-1:0]   pri;
        logic [TAG_W-1:0]   tag;
        logic [BYTES_W-1:0] bytes;
        logic [SEQ_W-1:0]   seq;
    } t_entry;

    typedef struct packed {
        logic insert;
        logic pop;
    } t_cell_cmd;

endpackage

`default_nettype wire

@@ rtl/core/pfts_cell.sv @@
// One slot of the sorted transmit queue: holds a frame entry and its
// occupied flag, shifts with its neighbors. Depends on pfts_pkg.
`default_nettype none

module pfts_cell (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire pfts_pkg::t_cell_cmd i_cmd,
    input  wire pfts_pkg::t_entry   i_new,
    input  wire pfts_pkg::t_entry   i_left,
    input  wire                     i_left_occ,
    input  wire                     i_left_ge,
    input  wire pfts_pkg::t_entry   i_right,
    input  wire                     i_right_occ,
    output pfts_pkg::t_entry        o_entry,
    output logic                    o_occ,
    output logic                    o_ge
);
    import pfts_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   r_occ;
    logic   n_occ;

    assign o_entry = r_entry;
    assign o_occ   = r_occ;
    assign o_ge    = r_occ && (r_entry.pri >= i_new.pri);

    always_comb begin
        n_entry = r_entry;
        n_occ   = r_occ;
        if (i_cmd.pop) begin
            n_entry = i_right;
            n_occ   = i_right_occ;
        end else if (i_cmd.insert && !o_ge) begin
            if (i_left_ge) begin
                n_entry = i_new;
                n_occ   = 1'b1;
            end else begin
                n_entry = i_left;
                n_occ   = i_left_occ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

@@ rtl/core/priority_frame_tx_scheduler.sv @@
// Top level of the priority frame transmit scheduler: request decode,
// port timing, sorted queue chain and result register. Uses pfts_pkg, pfts_cell.
// Latency: a result appears registered on the cycle after the request transfer.
// Throughput: one request per cycle; a sorted insert or a head pop is one shift
// of the cell chain, and the port timer takes one tick per cycle.
// Input stalls only while a result waits and the output is stalled.
// Reset (synchronous, active low) empties the queue, idles the port, restores defaults.
`default_nettype none

module priority_frame_tx_scheduler #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire                             i_req_type,
    input  wire  [pfts_pkg::PRI_W-1:0]      i_priority_req,
    input  wire  [pfts_pkg::BYTES_W-1:0]    i_length_bytes,
    input  wire  [pfts_pkg::TAG_W-1:0]      i_frame_tag,
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output logic [1:0]                      o_event_kind,
    output logic [pfts_pkg::TAG_W-1:0]      o_out_tag,
    output logic [pfts_pkg::PRI_W-1:0]      o_out_priority,
    output logic [pfts_pkg::BYTES_W-1:0]    o_frame_bytes,
    output logic [pfts_pkg::SEQ_W-1:0]      o_sequence_res,
    input  wire                             i_cfg_we,
    input  wire  [pfts_pkg::CIDX_W-1:0]     i_cfg_idx,
    input  wire  [pfts_pkg::CFG_W-1:0]      i_cfg_data
);
    import pfts_pkg::*;

    logic             r_switch;
    logic [REG_W-1:0] r_header;
    logic [REG_W-1:0] r_bpt;
    logic [SEQ_W-1:0] r_next_seq;
    logic [SEQ_W-1:0] n_next_seq;

    t_port             r_port;
    t_port             n_port;
    logic [BITS_W-1:0] r_bits_left;
    logic [BITS_W-1:0] n_bits_left;

    logic   r_out_valid;
    t_entry r_out;
    logic [1:0] r_out_kind;

    t_entry     w_cell [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_occ;
    logic [QUEUE_DEPTH-1:0] w_ge;
    t_cell_cmd  w_cmd;

    logic w_in_accept, w_enq, w_tick, w_oversize, w_full, w_enq_ok;
    logic w_direct, w_insert, w_gt, w_gap_gt, w_port_free, w_pop, w_launch, w_result;
    logic [BYTES_W-1:0] w_padded;
    logic [BYTES_W:0]   w_sum;
    logic [BYTES_W-1:0] w_norm_bytes;
    logic [REG_W-1:0]   w_rem;
    logic [REG_W-1:0]   w_rem2;
    t_entry     w_new;
    t_entry     w_launch_entry;
    t_entry     w_res_entry;
    logic [1:0] w_res_kind;

    // Request decode and frame length
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_enq       = w_in_accept && (i_req_type == REQ_ENQUEUE);
    assign w_tick      = w_in_accept && (i_req_type == REQ_TICK);

    assign w_padded     = (i_length_bytes < MIN_PAYLOAD) ? MIN_PAYLOAD : i_length_bytes;
    assign w_sum        = {1'b0, w_padded} + {{(BYTES_W + 1 - REG_W){1'b0}}, r_header};
    assign w_norm_bytes = w_sum[BYTES_W] ? BYTES_MAX : w_sum[BYTES_W-1:0];

    assign w_new.pri   = i_priority_req;
    assign w_new.tag   = i_frame_tag;
    assign w_new.bytes = r_switch ? i_length_bytes : w_norm_bytes;
    assign w_new.seq   = r_switch ? '0 : r_next_seq;

    assign w_oversize = w_enq && !r_switch && (i_length_bytes > MAX_PAYLOAD);
    assign w_full     = w_occ[QUEUE_DEPTH-1];
    assign w_enq_ok   = w_enq && !w_oversize && !w_full;
    assign w_direct   = w_enq_ok && (r_port == PORT_IDLE);
    assign w_insert   = w_enq_ok && (r_port != PORT_IDLE);

    // Port timing
    assign w_rem    = (r_bpt == '0) ? BPT_RESET : r_bpt;
    assign w_gt     = r_bits_left > {{(BITS_W - REG_W){1'b0}}, w_rem};
    assign w_rem2   = w_rem - r_bits_left[REG_W-1:0];
    assign w_gap_gt = GAP_BITS > w_rem2;

    always_comb begin
        w_port_free = 1'b0;
        unique case (r_port)
            PORT_TX:   w_port_free = w_tick && !w_gt && !w_gap_gt;
            PORT_GAP:  w_port_free = w_tick && !w_gt;
            PORT_IDLE: w_port_free = 1'b0;
            default:   w_port_free = 1'b0;
        endcase
    end

    assign w_pop    = w_port_free && w_occ[0];
    assign w_launch = w_direct || w_pop;

    assign w_launch_entry = w_direct ? w_new : w_cell[0];

    // Result selection
    always_comb begin
        w_result    = 1'b1;
        w_res_kind  = EV_LAUNCH;
        w_res_entry = w_launch_entry;
        if (w_oversize) begin
            w_res_kind        = EV_DROP_SIZE;
            w_res_entry       = w_new;
            w_res_entry.bytes = i_length_bytes;
            w_res_entry.seq   = '0;
        end else if (w_enq && w_full) begin
            w_res_kind      = EV_DROP_FULL;
            w_res_entry     = w_new;
            w_res_entry.seq = '0;
        end else if (!w_launch) begin
            w_result = 1'b0;
        end
    end

    // Port next state
    always_comb begin
        n_port      = r_port;
        n_bits_left = r_bits_left;
        unique case (r_port) inside
            PORT_IDLE: begin
                if (w_direct) begin
                    n_port      = PORT_TX;
                    n_bits_left = {1'b0, w_new.bytes, 3'b000};
                end
            end
            PORT_TX, PORT_GAP: begin
                if (w_tick) begin
                    if (w_gt) begin
                        n_bits_left = r_bits_left - {{(BITS_W - REG_W){1'b0}}, w_rem};
                    end else if ((r_port == PORT_TX) && w_gap_gt) begin
                        n_port      = PORT_GAP;
                        n_bits_left = {{(BITS_W - REG_W){1'b0}}, GAP_BITS - w_rem2};
                    end else if (w_occ[0]) begin
                        n_port      = PORT_TX;
                        n_bits_left = {1'b0, w_cell[0].bytes, 3'b000};
                    end else begin
                        n_port      = PORT_IDLE;
                        n_bits_left = '0;
                    end
                end
            end
            default: begin
                n_port      = PORT_IDLE;
                n_bits_left = '0;
            end
        endcase
    end

    always_comb begin
        n_next_seq = r_next_seq;
        if (i_cfg_we && (i_cfg_idx == CFG_SEQ_START)) begin
            n_next_seq = i_cfg_data[SEQ_W-1:0];
        end else if (w_enq_ok && !r_switch) begin
            n_next_seq = r_next_seq + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_switch    <= 1'b0;
            r_header    <= HDR_RESET;
            r_bpt       <= BPT_RESET;
            r_next_seq  <= '0;
            r_port      <= PORT_IDLE;
            r_bits_left <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SWITCH:    r_switch <= i_cfg_data[0];
                    CFG_HEADER:    r_header <= i_cfg_data[REG_W-1:0];
                    CFG_BPT:       r_bpt    <= i_cfg_data[REG_W-1:0];
                    CFG_SEQ_START: ;
                    default:       ;
                endcase
            end
            r_next_seq  <= n_next_seq;
            r_port      <= n_port;
            r_bits_left <= n_bits_left;
            if (w_in_accept && w_result) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept && w_result) begin
            r_out      <= w_res_entry;
            r_out_kind <= w_res_kind;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_kind   = r_out_kind;
    assign o_out_tag      = r_out.tag;
    assign o_out_priority = r_out.pri;
    assign o_frame_bytes  = r_out.bytes;
    assign o_sequence_res = r_out.seq;

    // Sorted queue chain
    assign w_cmd.insert = w_insert;
    assign w_cmd.pop    = w_pop;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry w_left;
        logic   w_left_occ;
        logic   w_left_ge;
        t_entry w_right;
        logic   w_right_occ;

        if (g == 0) begin : g_first
            assign w_left     = w_new;
            assign w_left_occ = 1'b0;
            assign w_left_ge  = 1'b1;
        end else begin : g_mid
            assign w_left     = w_cell[g-1];
            assign w_left_occ = w_occ[g-1];
            assign w_left_ge  = w_ge[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_right     = w_cell[g];
            assign w_right_occ = 1'b0;
        end else begin : g_inner
            assign w_right     = w_cell[g+1];
            assign w_right_occ = w_occ[g+1];
        end

        pfts_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_new       (w_new),
            .i_left      (w_left),
            .i_left_occ  (w_left_occ),
            .i_left_ge   (w_left_ge),
            .i_right     (w_right),
            .i_right_occ (w_right_occ),
            .o_entry     (w_cell[g]),
            .o_occ       (w_occ[g]),
            .o_ge        (w_ge[g])
        );
    end

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_port == PORT_IDLE) |-> !w_occ[0])
        else $error("port idle with frames queued");

    a_idle_no_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_port == PORT_IDLE) |-> (r_bits_left == '0))
        else $error("port idle with bits pending");

    a_occ_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_occ + 1'b1) & w_occ) == '0)
        else $error("queue occupancy not contiguous");

    a_launch_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && w_launch) |=> (r_port == PORT_TX))
        else $error("launch did not start transmission");

    a_no_insert_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.insert && w_cmd.pop))
        else $error("insert and pop in one cycle");

endmodule

`default_nettype wire
